[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mma_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mma_pkg;

    localparam int DATA_BITS = 32;

    localparam logic [DATA_BITS-1:0] MODULUS_RESET     = 32'h7FFE_0001;
    localparam logic [DATA_BITS-1:0] NEG_INVERSE_RESET = 32'h7FFD_FFFF;
    localparam logic [DATA_BITS-1:0] R_SQUARED_RESET   = 32'h002F_FFE4;

    typedef enum logic [1:0] {
        CFG_MODULUS     = 2'd0,
        CFG_NEG_INVERSE = 2'd1,
        CFG_R_SQUARED   = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_TO_MONT   = 2'd0,
        MODE_FROM_MONT = 2'd1,
        MODE_MUL       = 2'd2,
        MODE_POW       = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        SRC_A_R2,
        SRC_A_ONE,
        SRC_A_B,
        SRC_R2_ONE,
        SRC_ACC_BASE,
        SRC_BASE_BASE
    } src_t;

    typedef enum logic [1:0] {
        PH_OPS,
        PH_M,
        PH_P
    } phase_t;

    typedef enum logic {
        DST_ACC,
        DST_BASE
    } dst_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_T,
        ST_MUL_M,
        ST_MUL_P,
        ST_RED,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        STEP_SINGLE,
        STEP_INIT,
        STEP_ACC,
        STEP_SQR
    } step_t;

    typedef struct packed {
        logic   load;
        logic   mul_en;
        phase_t phase;
        src_t   src;
        logic   red_en;
        dst_t   dst;
        logic   exp_shift;
        logic   push;
    } dp_cmd_t;

    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
        logic exp_bit1;
        logic exp_rest_zero;
        logic out_full;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/mma_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mma_datapath
    import mma_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [DATA_BITS-1:0] cfg_data,
    input  wire logic [DATA_BITS-1:0] operand_a,
    input  wire logic [DATA_BITS-1:0] operand_b,
    input  wire dp_cmd_t              cmd,
    output dp_status_t                status,
    output logic [DATA_BITS-1:0]      result,
    output logic                      out_valid,
    input  wire logic                 out_ready
);

    localparam int W = WORD_BITS;

    logic [DATA_BITS-1:0] modulus_reg;
    logic [DATA_BITS-1:0] neg_inverse_reg;
    logic [DATA_BITS-1:0] r_squared_reg;

    logic [W-1:0]         base_reg, base_next;
    logic [W-1:0]         exp_reg, exp_next;
    logic [W-1:0]         acc_reg, acc_next;
    logic [2*W-1:0]       prod_reg, prod_next;
    logic [2*W-1:0]       t_reg, t_next;
    logic [DATA_BITS-1:0] out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic [W-1:0]   p_w;
    logic [W-1:0]   ninv_w;
    logic [W-1:0]   r2_w;
    logic [W-1:0]   mul_a;
    logic [W-1:0]   mul_b;
    logic [2*W-1:0] mul_out;
    logic [W:0]     red_sum;
    logic [W+1:0]   red_diff;
    logic [W-1:0]   red_val;

    assign p_w    = modulus_reg[W-1:0];
    assign ninv_w = neg_inverse_reg[W-1:0];
    assign r2_w   = r_squared_reg[W-1:0];

    always_comb
    begin
        mul_a = base_reg;
        mul_b = base_reg;
        case (cmd.phase)
            PH_OPS:
            begin
                case (cmd.src)
                    SRC_A_R2:      begin mul_a = base_reg; mul_b = r2_w;     end
                    SRC_A_ONE:     begin mul_a = base_reg; mul_b = W'(1);    end
                    SRC_A_B:       begin mul_a = base_reg; mul_b = exp_reg;  end
                    SRC_R2_ONE:    begin mul_a = r2_w;     mul_b = W'(1);    end
                    SRC_ACC_BASE:  begin mul_a = acc_reg;  mul_b = base_reg; end
                    SRC_BASE_BASE: begin mul_a = base_reg; mul_b = base_reg; end
                    default:       begin mul_a = base_reg; mul_b = base_reg; end
                endcase
            end
            PH_M:
            begin
                mul_a = prod_reg[W-1:0];
                mul_b = ninv_w;
            end
            PH_P:
            begin
                mul_a = prod_reg[W-1:0];
                mul_b = p_w;
            end
            default:
            begin
                mul_a = base_reg;
                mul_b = base_reg;
            end
        endcase
    end

    assign mul_out = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};

    // The low halves of T and m*p sum to zero or R, so the carry is set when T is
    // nonzero in its low half.
    assign red_sum  = {1'b0, t_reg[2*W-1:W]} + {1'b0, prod_reg[2*W-1:W]}
                    + {{W{1'b0}}, (t_reg[W-1:0] != '0)};
    assign red_diff = {1'b0, red_sum} - {2'b00, p_w};
    assign red_val  = red_diff[W+1] ? red_sum[W-1:0] : red_diff[W-1:0];

    always_comb
    begin
        base_next      = base_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        t_next         = t_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (cmd.load)
        begin
            base_next = operand_a[W-1:0];
            exp_next  = operand_b[W-1:0];
        end
        if (cmd.mul_en)
        begin
            prod_next = mul_out;
            if (cmd.phase == PH_M)
            begin
                t_next = prod_reg;
            end
        end
        if (cmd.red_en)
        begin
            if (cmd.dst == DST_BASE)
            begin
                base_next = red_val;
            end
            else
            begin
                acc_next = red_val;
            end
        end
        if (cmd.exp_shift)
        begin
            exp_next = exp_reg >> 1;
        end
        if (cmd.push)
        begin
            out_next       = DATA_BITS'(acc_reg);
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg     <= MODULUS_RESET;
            neg_inverse_reg <= NEG_INVERSE_RESET;
            r_squared_reg   <= R_SQUARED_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODULUS:     modulus_reg     <= cfg_data;
                    CFG_NEG_INVERSE: neg_inverse_reg <= cfg_data;
                    CFG_R_SQUARED:   r_squared_reg   <= cfg_data;
                    default:         ;
                endcase
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        exp_reg  <= exp_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        t_reg    <= t_next;
        out_reg  <= out_next;
    end

    assign status.exp_zero      = (exp_reg == '0);
    assign status.exp_lsb       = exp_reg[0];
    assign status.exp_bit1      = exp_reg[1];
    assign status.exp_rest_zero = (exp_reg[W-1:1] == '0);
    assign status.out_full      = out_valid_reg && !out_ready;

    assign result    = out_reg;
    assign out_valid = out_valid_reg;

    `ASSERT_SAME(a_push_no_overwrite, cmd.push, !(out_valid_reg && !out_ready),
        "A new word overwrote an output word that was not yet taken.")
    `ASSERT_SAME(a_red_not_with_mul, cmd.red_en, !cmd.mul_en && !cmd.load,
        "Reduction overlapped a multiply or a load.")

endmodule

`default_nettype wire

[rtl/core/mma_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mma_ctrl
    import mma_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] mode,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;
    step_t       step_reg, step_next;
    mode_t       mode_reg, mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_SINGLE;
            mode_reg  <= MODE_TO_MONT;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            mode_reg  <= mode_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        mode_next     = mode_reg;
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.mul_en    = 1'b0;
        cmd.phase     = PH_OPS;
        cmd.src       = SRC_A_R2;
        cmd.red_en    = 1'b0;
        cmd.dst       = DST_ACC;
        cmd.exp_shift = 1'b0;
        cmd.push      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    mode_next  = mode_t'(mode);
                    step_next  = (mode_t'(mode) == MODE_POW) ? STEP_INIT : STEP_SINGLE;
                    state_next = ST_MUL_T;
                end
            end
            ST_MUL_T:
            begin
                cmd.mul_en = 1'b1;
                cmd.phase  = PH_OPS;
                case (step_reg)
                    STEP_SINGLE:
                    begin
                        case (mode_reg)
                            MODE_TO_MONT:   cmd.src = SRC_A_R2;
                            MODE_FROM_MONT: cmd.src = SRC_A_ONE;
                            default:        cmd.src = SRC_A_B;
                        endcase
                    end
                    STEP_INIT: cmd.src = SRC_R2_ONE;
                    STEP_ACC:  cmd.src = SRC_ACC_BASE;
                    default:   cmd.src = SRC_BASE_BASE;
                endcase
                state_next = ST_MUL_M;
            end
            ST_MUL_M:
            begin
                cmd.mul_en = 1'b1;
                cmd.phase  = PH_M;
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                cmd.mul_en = 1'b1;
                cmd.phase  = PH_P;
                state_next = ST_RED;
            end
            ST_RED:
            begin
                cmd.red_en = 1'b1;
                case (step_reg)
                    STEP_SINGLE:
                    begin
                        state_next = ST_OUT;
                    end
                    STEP_INIT:
                    begin
                        if (status.exp_zero)
                        begin
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            step_next  = status.exp_lsb ? STEP_ACC : STEP_SQR;
                            state_next = ST_MUL_T;
                        end
                    end
                    STEP_ACC:
                    begin
                        // The square after the highest exponent bit is never used.
                        if (status.exp_rest_zero)
                        begin
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            step_next  = STEP_SQR;
                            state_next = ST_MUL_T;
                        end
                    end
                    default:
                    begin
                        cmd.dst       = DST_BASE;
                        cmd.exp_shift = 1'b1;
                        if (status.exp_rest_zero)
                        begin
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            step_next  = status.exp_bit1 ? STEP_ACC : STEP_SQR;
                            state_next = ST_MUL_T;
                        end
                    end
                endcase
            end
            ST_OUT:
            begin
                if (!status.out_full)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == ST_MUL_T,
        "An accepted word did not start a product.")
    `ASSERT_NEXT(a_mul_t_to_m, state_reg == ST_MUL_T, state_reg == ST_MUL_M,
        "The product sequence skipped the reduction factor pass.")
    `ASSERT_NEXT(a_red_exit, state_reg == ST_RED,
        state_reg == ST_MUL_T || state_reg == ST_OUT,
        "The reduction step was followed by an unexpected state.")
    `ASSERT_SAME(a_shift_only_square, cmd.exp_shift, cmd.red_en && cmd.dst == DST_BASE,
        "The exponent shifted outside a squaring reduction.")

endmodule

`default_nettype wire

[rtl/core/montgomery_modular_arith_32.sv]
`timescale 1ns / 1ps
`default_nettype none

// Montgomery arithmetic over a configured odd modulus with R = 2^WORD_BITS. Each input
// word selects conversion into Montgomery form, conversion out of it, a Montgomery
// product, or a power of a Montgomery base, and yields one output word. All work goes
// through one shared WORD_BITS by WORD_BITS multiplier: a Montgomery product takes three
// multiplier passes and one reduction step. Modes 0 to 2 use one product per word. Power
// uses one product to form the Montgomery one, then one product per set exponent bit and
// one squaring per exponent position below the highest set bit; a zero exponent needs
// only the first product. One word is worked on at a time, but a new word is accepted
// while the previous result still waits in the output register. Configuration writes
// must only happen while the block is idle.

module montgomery_modular_arith_32
    import mma_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // mode [1:0], operand_a [33:2], operand_b [65:34]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // result [31:0]
);

    dp_cmd_t    cmd;
    dp_status_t status;

    mma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .mode     (s_tdata[1:0]),
        .status   (status),
        .cmd      (cmd)
    );

    mma_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .operand_a (s_tdata[33:2]),
        .operand_b (s_tdata[65:34]),
        .cmd       (cmd),
        .status    (status),
        .result    (m_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

endmodule

`default_nettype wire
